// ===== rtl/rectangle_blitter_cycle_defines.svh =====
// Assertion macros shared by the rectangle blitter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef RECTANGLE_BLITTER_CYCLE_DEFINES_SVH
`define RECTANGLE_BLITTER_CYCLE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define RBC_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rbc: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define RBC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rbc: next-cycle check failed");

`endif

// ===== rtl/rbc_pkg.sv =====
// Types, codes and counter-update functions for the rectangle blitter.
// No dependencies; used by the channel interfaces and the top level.
package rbc_pkg;

    // Operation codes of an input item
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_DEST_X_START = 3'd0;
    localparam logic [2:0] REG_DEST_Y_START = 3'd1;
    localparam logic [2:0] REG_SRC_X_START  = 3'd2;
    localparam logic [2:0] REG_SRC_Y_START  = 3'd3;
    localparam logic [2:0] REG_WIDTH_DIR    = 3'd4;
    localparam logic [2:0] REG_HEIGHT_DIR   = 3'd5;
    localparam logic [2:0] REG_FILL_COLOR   = 3'd6;
    localparam logic [2:0] REG_CONTROL_BITS = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Control bit positions
    localparam int CTL_COPY_EN   = 0;
    localparam int CTL_FILL      = 1;
    localparam int CTL_OPAQUE    = 2;
    localparam int CTL_FULL_CARY = 3;
    localparam int CTL_WRAP_X    = 4;
    localparam int CTL_WRAP_Y    = 5;
    localparam int CTL_PAGE      = 6;
    localparam int CTL_BANK_LO   = 7;

    localparam int BANK_FIELD_W = 3;

    typedef struct packed {
        logic       op;
        logic       trigger_bit;
        logic [7:0] source_byte;
    } item_t;

    typedef struct packed {
        logic        write_enable;
        logic [14:0] write_address;
        logic [7:0]  write_data;
        logic        busy_res;
        logic        irq_flag;
        logic [18:0] next_source_address;
    } result_t;

    typedef struct packed {
        logic [7:0] dest_x_start;
        logic [7:0] dest_y_start;
        logic [7:0] src_x_start;
        logic [7:0] src_y_start;
        logic [7:0] width_dir;
        logic [7:0] height_dir;
        logic [7:0] fill_color;
        logic [9:0] control_bits;
    } cfg_t;

    typedef struct packed {
        logic       run_flag;
        logic       init_flag;
        logic       armed_flag;
        logic       done_flag;
        logic [6:0] width_left;
        logic [6:0] rows_left;
        logic [7:0] dest_x_count;
        logic [7:0] dest_y_count;
        logic [7:0] src_x_count;
        logic [7:0] src_y_count;
    } state_t;

    // Source counter step: full 8-bit increment or low nibble only
    function automatic logic [7:0] src_step(input logic [7:0] v, input logic full);
        logic [7:0] inc;
        inc = v + 8'd1;
        src_step = full ? inc : {v[7:4], inc[3:0]};
    endfunction

    // Phased counter update of one tick
    function automatic state_t count_phases(input state_t s_in, input cfg_t c);
        state_t     s;
        logic [6:0] wid;
        logic       full;
        s    = s_in;
        wid  = c.width_dir[6:0];
        full = c.control_bits[CTL_FULL_CARY];
        if (s.run_flag)
            s.width_left = s.width_left - 7'd1;
        if (s.init_flag)
            s.width_left = wid;
        if (s.run_flag)
        begin
            s.dest_x_count = s.dest_x_count + 8'd1;
            s.src_x_count  = src_step(s.src_x_count, full);
            if (s.width_left == 7'd0)
            begin
                s.dest_y_count = s.dest_y_count + 8'd1;
                s.src_y_count  = src_step(s.src_y_count, full);
                s.rows_left    = s.rows_left - 7'd1;
            end
        end
        if (s.width_left == 7'd0 || s.init_flag)
        begin
            s.dest_x_count = c.dest_x_start;
            s.src_x_count  = c.src_x_start;
        end
        if (s.init_flag)
        begin
            s.dest_y_count = c.dest_y_start;
            s.src_y_count  = c.src_y_start;
            s.rows_left    = c.height_dir[6:0];
        end
        if (s.rows_left == 7'd0)
        begin
            s.run_flag  = 1'b0;
            s.done_flag = 1'b1;
        end
        s.run_flag = s.run_flag || s.init_flag;
        if (s.width_left == 7'd0)
            s.width_left = wid;
        count_phases = s;
    endfunction

    // Source byte address from the source counters
    function automatic logic [18:0] source_address(input state_t s, input cfg_t c,
                                                   input logic [BANK_FIELD_W-1:0] mask);
        logic [7:0]              gx;
        logic [7:0]              gy;
        logic [BANK_FIELD_W-1:0] bank;
        gx   = c.width_dir[7]  ? ~s.src_x_count : s.src_x_count;
        gy   = c.height_dir[7] ? ~s.src_y_count : s.src_y_count;
        bank = c.control_bits[CTL_BANK_LO +: BANK_FIELD_W] & mask;
        source_address = {bank, gy[7], gx[7], gy[6:0], gx[6:0]};
    endfunction

endpackage

// ===== rtl/rbc_if.sv =====
// Valid/ready channel interfaces for the blitter's input items and results.
// Depends on rbc_pkg for the payload types.
interface rbc_item_if;
    import rbc_pkg::*;
    logic  valid;
    logic  ready;
    item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rbc_result_if;
    import rbc_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/rectangle_blitter_cycle.sv =====
// Rectangle blitter top level: input register, one-tick update, result register.
// Depends on rbc_pkg, rbc_if.sv and rectangle_blitter_cycle_defines.svh.
//
//  channel   dir  transfer rule         contents
//  item      in   valid & ready         op, trigger_bit, source_byte
//  result    out  valid & ready         write strobe, address, data, busy, irq, next addr
//  cfg       in   cfg_wr_en high        register index, write data
//
// One transaction per cycle sustained while the result side takes results; an item that
// is taken is held in the input register, then loaded into the result register and offered there.
// The blitter state advances when an item moves from the input register to the
// result register; a stalled result holds that move, and the input side keeps
// taking one more item until the input register is full.
// Reset clears the state, the configuration registers and both valid flags.
`include "rectangle_blitter_cycle_defines.svh"

module rectangle_blitter_cycle #(
    parameter int BANK_BITS = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rbc_item_if.sink                         item,
    rbc_result_if.source                     result,
    input  logic                             cfg_wr_en,
    input  logic [rbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import rbc_pkg::*;

    localparam logic [BANK_FIELD_W-1:0] BANK_MASK = BANK_FIELD_W'((1 << BANK_BITS) - 1);

    cfg_t    cfg_reg;
    state_t  st_reg;
    state_t  st_next;
    state_t  st_pred;
    logic    item_valid_reg;
    item_t   item_reg;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;
    logic    [7:0] colour;
    logic    wrap_x;
    logic    wrap_y;

    // Handshake: the input register drains into the result register
    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready   = !item_valid_reg || advance;
    assign result.valid = res_valid_reg;
    assign result.payload = res_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEST_X_START: cfg_reg.dest_x_start <= cfg_wr_data[7:0];
                REG_DEST_Y_START: cfg_reg.dest_y_start <= cfg_wr_data[7:0];
                REG_SRC_X_START:  cfg_reg.src_x_start  <= cfg_wr_data[7:0];
                REG_SRC_Y_START:  cfg_reg.src_y_start  <= cfg_wr_data[7:0];
                REG_WIDTH_DIR:    cfg_reg.width_dir    <= cfg_wr_data[7:0];
                REG_HEIGHT_DIR:   cfg_reg.height_dir   <= cfg_wr_data[7:0];
                REG_FILL_COLOR:   cfg_reg.fill_color   <= cfg_wr_data[7:0];
                REG_CONTROL_BITS: cfg_reg.control_bits <= cfg_wr_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item.ready)
            item_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.payload;
    end

    // Colour for the destination write
    assign colour = cfg_reg.control_bits[CTL_FILL] ? ~cfg_reg.fill_color
                                                   : item_reg.source_byte;

    // One step: trigger write or tick, then the write strobe, status and next source address
    always_comb
    begin
        st_next  = st_reg;
        res_next = '0;
        wrap_x   = 1'b0;
        wrap_y   = 1'b0;
        if (item_reg.op == OP_TRIGGER)
        begin
            st_next.armed_flag = item_reg.trigger_bit;
            st_next.done_flag  = 1'b0;
        end
        else
        begin
            st_next            = count_phases(st_reg, cfg_reg);
            st_next.init_flag  = st_next.armed_flag;
            st_next.armed_flag = 1'b0;
            wrap_x = st_next.dest_x_count[7] && cfg_reg.control_bits[CTL_WRAP_X];
            wrap_y = st_next.dest_y_count[7] && cfg_reg.control_bits[CTL_WRAP_Y];
            if (st_next.run_flag && cfg_reg.control_bits[CTL_COPY_EN]
                && (cfg_reg.control_bits[CTL_OPAQUE] || colour != 8'd0)
                && !wrap_x && !wrap_y)
            begin
                res_next.write_enable  = 1'b1;
                res_next.write_address = {cfg_reg.control_bits[CTL_PAGE],
                                          st_next.dest_y_count[6:0],
                                          st_next.dest_x_count[6:0]};
                res_next.write_data    = colour;
            end
        end
        st_pred = count_phases(st_next, cfg_reg);
        res_next.busy_res            = st_next.run_flag;
        res_next.irq_flag            = st_next.done_flag;
        res_next.next_source_address = source_address(st_pred, cfg_reg, BANK_MASK);
    end

    // Blitter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (advance)
            st_reg <= st_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (result.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // Checks
    `RBC_ASSERT_SAME(a_write_needs_busy, clk, rst_n,
        res_valid_reg && res_reg.write_enable, res_reg.busy_res)
    `RBC_ASSERT_SAME(a_idle_write_zero, clk, rst_n,
        res_valid_reg && !res_reg.write_enable,
        res_reg.write_address == 15'd0 && res_reg.write_data == 8'd0)
    `RBC_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, res_valid_reg)
    `RBC_ASSERT_NEXT(a_trigger_result, clk, rst_n, advance && item_reg.op == OP_TRIGGER,
        !res_reg.write_enable && !res_reg.irq_flag)

endmodule

// ===== tb/rectangle_blitter_cycle_test.sv =====
// Self-checking testbench for the rectangle blitter: directed table, then random copy phases.
// Depends on rbc_pkg, the rbc_if channel interfaces and the rectangle_blitter_cycle top level.
module rectangle_blitter_cycle_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbc_pkg::*;

    localparam int BANK_W       = 3;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_MAX   = 10;

    localparam logic [BANK_FIELD_W-1:0] BANK_MASK = BANK_FIELD_W'((1 << BANK_W) - 1);

    // Shadow copy of the blitter counters and flags
    typedef struct packed {
        logic       running;
        logic       starting;
        logic       armed;
        logic       done;
        logic [6:0] cols_left;
        logic [6:0] rows_left;
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] sx;
        logic [7:0] sy;
    } blit_track_t;

    // Shadow copy of the register file, in register index order
    typedef struct packed {
        logic [7:0] dest_x0;
        logic [7:0] dest_y0;
        logic [7:0] src_x0;
        logic [7:0] src_y0;
        logic [7:0] width_dir;
        logic [7:0] height_dir;
        logic [7:0] fill;
        logic [9:0] ctrl;
    } blit_regs_t;

    typedef enum {ROW_ITEM, ROW_REGS} row_kind_t;

    typedef struct {
        row_kind_t  kind;
        item_t      stim;
        bit         typed;
        result_t    want;
        blit_regs_t regs;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    rbc_item_if   item_ch ();
    rbc_result_if result_ch ();

    rectangle_blitter_cycle #(
        .BANK_BITS (BANK_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    blit_track_t blit_now;
    blit_regs_t  blit_regs;
    result_t     due_results[$];
    plan_row_t   plan[$];

    int  errors;
    int  items_sent;
    int  ticks_sent;
    int  triggers_sent;
    int  writes_seen;
    int  irq_seen;
    int  phases_run;
    int  holds_done;
    int  steady_left;
    bit  hold_req;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still due", due_results.size());
        $display("rectangle_blitter_cycle verification failed");
        $finish;
    end

    // Source counter step: full carry or low nibble only
    function automatic logic [7:0] src_next(input logic [7:0] v, input blit_regs_t r);
        logic [7:0] inc;
        inc = v + 8'd1;
        if (r.ctrl[CTL_FULL_CARY])
            return inc;
        return {v[7:4], inc[3:0]};
    endfunction

    // Counter phases of one tick, up to the write strobe
    function automatic blit_track_t advance_counters(input blit_track_t s, input blit_regs_t r);
        logic [6:0] wid;
        wid = r.width_dir[6:0];
        if (s.running)
            s.cols_left = s.cols_left - 7'd1;
        if (s.starting)
            s.cols_left = wid;
        if (s.running)
        begin
            s.dx = s.dx + 8'd1;
            s.sx = src_next(s.sx, r);
            if (s.cols_left == 7'd0)
            begin
                s.dy        = s.dy + 8'd1;
                s.sy        = src_next(s.sy, r);
                s.rows_left = s.rows_left - 7'd1;
            end
        end
        // row start reloads x
        if (s.cols_left == 7'd0 || s.starting)
        begin
            s.dx = r.dest_x0;
            s.sx = r.src_x0;
        end
        if (s.starting)
        begin
            s.dy        = r.dest_y0;
            s.sy        = r.src_y0;
            s.rows_left = r.height_dir[6:0];
        end
        if (s.rows_left == 7'd0)
        begin
            s.running = 1'b0;
            s.done    = 1'b1;
        end
        s.running = s.running || s.starting;
        if (s.cols_left == 7'd0)
            s.cols_left = wid;
        return s;
    endfunction

    // Source byte address, with direction inversion and bank
    function automatic logic [18:0] fetch_address(input blit_track_t s, input blit_regs_t r);
        logic [7:0]              gx;
        logic [7:0]              gy;
        logic [BANK_FIELD_W-1:0] bank;
        gx   = r.width_dir[7] ? ~s.sx : s.sx;
        gy   = r.height_dir[7] ? ~s.sy : s.sy;
        bank = r.ctrl[CTL_BANK_LO +: BANK_FIELD_W] & BANK_MASK;
        return {bank, gy[7], gx[7], gy[6:0], gx[6:0]};
    endfunction

    // Advance the shadow state by one transaction and return the result it yields
    function automatic result_t blit_tick_result(input item_t it);
        result_t    res;
        logic [7:0] colour;
        logic       clip_x;
        logic       clip_y;
        res = '0;
        if (it.op == OP_TRIGGER)
        begin
            blit_now.armed = it.trigger_bit;
            blit_now.done  = 1'b0;
        end
        else
        begin
            blit_now          = advance_counters(blit_now, blit_regs);
            blit_now.starting = blit_now.armed;
            blit_now.armed    = 1'b0;
            if (blit_now.running && blit_regs.ctrl[CTL_COPY_EN])
            begin
                colour = blit_regs.ctrl[CTL_FILL] ? ~blit_regs.fill : it.source_byte;
                clip_x = blit_now.dx[7] & blit_regs.ctrl[CTL_WRAP_X];
                clip_y = blit_now.dy[7] & blit_regs.ctrl[CTL_WRAP_Y];
                // zero bytes are skipped unless opaque
                if ((blit_regs.ctrl[CTL_OPAQUE] || colour != 8'd0) && !clip_x && !clip_y)
                begin
                    res.write_enable  = 1'b1;
                    res.write_address = {blit_regs.ctrl[CTL_PAGE], blit_now.dy[6:0],
                                         blit_now.dx[6:0]};
                    res.write_data    = colour;
                end
            end
        end
        res.busy_res            = blit_now.running;
        res.irq_flag            = blit_now.done;
        res.next_source_address = fetch_address(advance_counters(blit_now, blit_regs),
                                                blit_regs);
        return res;
    endfunction

    // Offer one transaction, wait for acceptance, then maybe leave a gap
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        int      gap;
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = blit_tick_result(it);
        due_results.push_back(typed ? want : predicted);
        items_sent++;
        if (it.op == OP_TRIGGER)
            triggers_sent++;
        else
            ticks_sent++;
        gap = 0;
        if (steady_left > 0)
            steady_left--;
        else
        begin
            case ($urandom_range(0, 31))
                20, 21, 22, 23, 24, 25, 26, 27: gap = $urandom_range(1, 3);
                28, 29:                         gap = $urandom_range(4, 8);
                30:                             gap = $urandom_range(15, 40);
                31:                             steady_left = $urandom_range(30, 100);
                default:                        gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every due result has arrived
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all eight registers, with junk in the unused upper data bits
    task automatic write_regs(input blit_regs_t r);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[REG_DEST_X_START] = {2'($urandom_range(0, 3)), r.dest_x0};
        vals[REG_DEST_Y_START] = {2'($urandom_range(0, 3)), r.dest_y0};
        vals[REG_SRC_X_START]  = {2'($urandom_range(0, 3)), r.src_x0};
        vals[REG_SRC_Y_START]  = {2'($urandom_range(0, 3)), r.src_y0};
        vals[REG_WIDTH_DIR]    = {2'($urandom_range(0, 3)), r.width_dir};
        vals[REG_HEIGHT_DIR]   = {2'($urandom_range(0, 3)), r.height_dir};
        vals[REG_FILL_COLOR]   = {2'($urandom_range(0, 3)), r.fill};
        vals[REG_CONTROL_BITS] = r.ctrl;
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= i[CFG_INDEX_W-1:0];
            cfg_wr_data <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        blit_regs = r;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly small rectangles; now and then zero (wraps to 128) or the largest
    function automatic logic [7:0] pick_size();
        logic [6:0] n;
        case ($urandom_range(0, 9))
            0:       n = 7'h00;
            1:       n = 7'h7F;
            default: n = 7'($urandom_range(1, 6));
        endcase
        return {1'($urandom_range(0, 1)), n};
    endfunction

    function automatic void plan_item(input logic op, input logic trig, input logic [7:0] b,
                                      input bit typed, input logic irq);
        plan_row_t row;
        row.kind              = ROW_ITEM;
        row.stim.op           = op;
        row.stim.trigger_bit  = trig;
        row.stim.source_byte  = b;
        row.typed             = typed;
        row.want              = '0;
        row.want.irq_flag     = irq;
        row.regs              = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_regs(input blit_regs_t r);
        plan_row_t row;
        row.kind  = ROW_REGS;
        row.stim  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        row.regs  = r;
        plan.push_back(row);
    endfunction

    // One random phase: registers, then usually a trigger and up to 80 ticks for the copy
    task automatic run_phase(input int phase_no);
        blit_regs_t r;
        item_t      it;
        int         ticks;
        bit         well_formed;
        drain_results();
        case (phase_no)
            0: r = '1;
            1: r = '0;
            default:
            begin
                r.dest_x0    = pick_byte();
                r.dest_y0    = pick_byte();
                r.src_x0     = pick_byte();
                r.src_y0     = pick_byte();
                r.width_dir  = pick_size();
                r.height_dir = pick_size();
                r.fill       = pick_byte();
                r.ctrl       = 10'($urandom_range(0, 1023));
                if ($urandom_range(0, 3) != 0)
                    r.ctrl[CTL_COPY_EN] = 1'b1;
            end
        endcase
        write_regs(r);
        phases_run++;
        ticks = int'(r.width_dir[6:0]) * int'(r.height_dir[6:0]) + $urandom_range(2, 8);
        if (ticks > 80)
            ticks = 80;
        // long receiver hold-off while the sender keeps offering
        if (phase_no == 2)
        begin
            hold_req    = 1'b1;
            steady_left = 200;
            ticks       = 60;
        end
        well_formed = ($urandom_range(0, 4) != 0);
        if (well_formed)
        begin
            it.op          = OP_TRIGGER;
            it.trigger_bit = 1'b1;
            it.source_byte = pick_byte();
            send_item(it, 1'b0, '0);
        end
        for (int k = 0; k < ticks; k++)
        begin
            it.op          = OP_TICK;
            it.trigger_bit = 1'($urandom_range(0, 1));
            if ((!well_formed && $urandom_range(0, 3) == 0) || $urandom_range(0, 39) == 0)
                it.op = OP_TRIGGER;
            it.source_byte = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result receiver: random stalls, calm stretches, one long hold-off on request
    initial
    begin
        int stall_left;
        int free_left;
        stall_left      = 0;
        free_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                holds_done++;
                result_ch.ready <= 1'b0;
            end
            else if (free_left > 0)
            begin
                free_left--;
                result_ch.ready <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 31))
                    22, 23, 24, 25, 26, 27:
                    begin
                        stall_left = $urandom_range(0, 2);
                        result_ch.ready <= 1'b0;
                    end
                    28, 29:
                    begin
                        stall_left = $urandom_range(3, 8);
                        result_ch.ready <= 1'b0;
                    end
                    30:
                    begin
                        stall_left = $urandom_range(15, 40);
                        result_ch.ready <= 1'b0;
                    end
                    31:
                    begin
                        free_left = $urandom_range(30, 120);
                        result_ch.ready <= 1'b1;
                    end
                    default: result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        bit      bad;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.payload;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: result with nothing due: %h", $realtime, got);
            end
            else
            begin
                want = due_results.pop_front();
                bad  = (got.write_enable !== want.write_enable)
                    || (got.write_address !== want.write_address)
                    || (got.write_data !== want.write_data)
                    || (got.busy_res !== want.busy_res)
                    || (got.irq_flag !== want.irq_flag)
                    || (got.next_source_address !== want.next_source_address);
                if (bad)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                    begin
                        $write("%0t: mismatch (exp/act) we %b/%b addr %h/%h data %h/%h ",
                               $realtime,
                               want.write_enable, got.write_enable,
                               want.write_address, got.write_address,
                               want.write_data, got.write_data);
                        $display("busy %b/%b irq %b/%b next %h/%h",
                                 want.busy_res, got.busy_res,
                                 want.irq_flag, got.irq_flag,
                                 want.next_source_address, got.next_source_address);
                    end
                end
                if (got.write_enable === 1'b1)
                    writes_seen++;
                if (got.irq_flag === 1'b1)
                    irq_seen++;
            end
        end
    end

    // Stimulus
    initial
    begin
        int directed_items;
        int phase_no;
        errors        = 0;
        items_sent    = 0;
        ticks_sent    = 0;
        triggers_sent = 0;
        writes_seen   = 0;
        irq_seen      = 0;
        phases_run    = 0;
        holds_done    = 0;
        steady_left   = 0;
        hold_req      = 1'b0;
        blit_now      = '0;
        blit_regs     = '0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_wr_data     = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset: empty countdowns report done, no writes, address 0
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b1, 1'b1);
        plan_item(OP_TICK, 1'b1, 8'hFF, 1'b1, 1'b1);
        // trigger write clears irq
        plan_item(OP_TRIGGER, 1'b0, 8'h5A, 1'b1, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b1, 1'b1);
        // all control bits, inverted source, one row from x 126 to 127 under wrapx
        // fields: dest_x0, dest_y0, src_x0, src_y0, width_dir, height_dir, fill, ctrl
        plan_regs('{8'h7E, 8'h7F, 8'hFF, 8'h00, 8'h82, 8'h81, 8'h00, 10'h3FF});
        plan_item(OP_TRIGGER, 1'b1, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'hFF, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b1, 8'h80, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h01, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h7F, 1'b0, 1'b0);
        // zero width, transparent copy with nibble carry, dest at 255
        plan_regs('{8'hFF, 8'hFF, 8'h0F, 8'hF0, 8'h00, 8'h01, 8'hA5, 10'h001});
        plan_item(OP_TRIGGER, 1'b1, 8'hFF, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'hFF, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h33, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h01, 1'b0, 1'b0);
        // zero height, fill to page 1 from bank 5
        plan_regs('{8'h10, 8'h20, 8'h30, 8'h40, 8'h03, 8'h80, 8'hA5, 10'h2C3});
        plan_item(OP_TRIGGER, 1'b1, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'hC3, 1'b0, 1'b0);
        plan_item(OP_TICK, 1'b0, 8'h00, 1'b0, 1'b0);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REGS)
            begin
                drain_results();
                write_regs(plan[i].regs);
            end
            else
                send_item(plan[i].stim, plan[i].typed, plan[i].want);
        end
        directed_items = items_sent;

        // Random copy phases
        phase_no = 0;
        while (items_sent - directed_items < RANDOM_ITEMS)
        begin
            run_phase(phase_no);
            phase_no++;
        end

        drain_results();
        repeat (10) @(posedge clk);
        $display("covered %0d transactions (%0d ticks, %0d triggers) over %0d register settings",
                 items_sent, ticks_sent, triggers_sent, phases_run + 3);
        $display("saw %0d pixel writes, %0d results with irq set, %0d long output hold-offs",
                 writes_seen, irq_seen, holds_done);
        if (errors == 0)
            $display("rectangle_blitter_cycle verification clean");
        else
            $display("rectangle_blitter_cycle verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rbc_pkg.sv
rtl/rbc_if.sv
rtl/rectangle_blitter_cycle.sv
tb/rectangle_blitter_cycle_test.sv
